// ----- rtl/core/fpadd_pkg.sv -----
// Package for the binary16 adder with round-to-odd.
// Format constants and special result codes. No dependencies.
`default_nettype none
package fpadd_pkg;
    localparam logic [15:0] H_NAN     = 16'h7E00;
    localparam logic [14:0] H_MAXMAG  = 15'h7BFF;
    localparam int          H_BIAS    = 15;
    localparam int          H_EXTRA   = 20;
    localparam logic [4:0]  H_EXPSPC  = 5'd31;
    localparam int          H_FRACB   = 10;
    localparam int          H_LEAD    = H_FRACB + H_EXTRA;
endpackage
`default_nettype wire

// ----- rtl/core/fp16_adder_round_to_odd.sv -----
// Top level of the binary16 adder with round-to-odd.
// Depends on fpadd_pkg.
//
// Usage:
//   Drive i_a_operand and i_b_operand with start high; an item is taken at
//   every rising edge where start is high and busy is low. busy is
//   always low, so an item can be taken in every cycle.
//   Operands are registered at the input; the sum is computed by one pass of
//   combinational logic (align, add, normalise, round) and registered into
//   the result register. o_sum_value is valid for exactly one cycle with
//   o_done high, starting at the edge after the item is taken.
//   Throughput: one item per cycle. Each item passes through the input
//   register and the result register.
//   Reset (synchronous, active low) clears the valid flags only; no item in
//   flight survives it.
//   The receiver cannot stall: each result must be taken in its cycle.
//   No kept state between items.
`default_nettype none
module fp16_adder_round_to_odd (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_a_operand,
    input  wire logic [15:0] i_b_operand,
    output logic             o_done,
    output logic [15:0]      o_sum_value
);
    logic        r_in_vld, r_out_vld;
    logic [15:0] r_a, r_b, r_sum, n_sum;

    assign busy        = 1'b0;
    assign o_done      = r_out_vld;
    assign o_sum_value = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_a <= i_a_operand;
            r_b <= i_b_operand;
        end
        if (r_in_vld) begin
            r_sum <= n_sum;
        end
    end

    // datapath
    logic [15:0] a, b;
    logic        sa, sb;
    logic [4:0]  ea, eb;
    logic [9:0]  fa, fb;
    logic [5:0]  dexp;
    logic [31:0] ma, mb, mbs, lostm, r, r1, rn, rd, lostd;
    logic [7:0]  re;         // unbiased-plus-bias exponent, signed
    logic [4:0]  pos;
    logic [4:0]  lsh;
    logic [7:0]  rexp;
    logic [5:0]  dsh;
    logic [10:0] rm;

    always_comb begin
        a = r_a;
        b = r_b;
        if (r_a[14:0] < r_b[14:0]) begin
            a = r_b;
            b = r_a;
        end
        sa = a[15]; ea = a[14:10]; fa = a[9:0];
        sb = b[15]; eb = b[14:10]; fb = b[9:0];
        ma = {1'b0, (ea != 5'd0), fa, 20'd0};
        mb = {1'b0, (eb != 5'd0), fb, 20'd0};
        dexp = {1'b0, ea | {4'd0, ea == 5'd0}} - {1'b0, eb | {4'd0, eb == 5'd0}};
        if (dexp > 6'd31) dexp = 6'd31;
        lostm = mb & ((32'd1 << dexp[4:0]) - 32'd1);
        mbs   = (mb >> dexp[4:0]) | {31'd0, lostm != 32'd0};
        r  = (sa == sb) ? ma + mbs : ma - mbs;
        re = {3'd0, ea | {4'd0, ea == 5'd0}};
        r1 = r;
        if (r[31]) begin
            r1 = (r >> 1) | {31'd0, r[0]};
            re = re + 8'd1;
        end
        pos = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (r1[i]) pos = 5'(i);
        end
        rn   = r1;
        rexp = re;
        lsh  = 5'd0;
        if (pos < 5'(fpadd_pkg::H_LEAD)) begin
            lsh  = 5'(fpadd_pkg::H_LEAD) - pos;
            rn   = r1 << lsh;
            rexp = re - {3'd0, lsh};
        end
        rd  = rn;
        dsh = 6'd0;
        if (rexp[7] || rexp == 8'd0) begin
            dsh = (8'd1 - rexp > 8'd31) ? 6'd31 : 6'(8'd1 - rexp);
            lostd = rn & ((32'd1 << dsh[4:0]) - 32'd1);
            rd = (rn >> dsh[4:0]) | {31'd0, lostd != 32'd0};
        end else begin
            lostd = 32'd0;
        end
        rm = rd[30:20] | {10'd0, rd[19:0] != 20'd0};

        if (r_a[14:0] == 15'd0 && r_b[14:0] == 15'd0)
            n_sum = r_a & r_b;
        else if (ea == fpadd_pkg::H_EXPSPC) begin
            if (fa != 10'd0 || (eb == fpadd_pkg::H_EXPSPC && (fb != 10'd0 || sa != sb)))
                n_sum = fpadd_pkg::H_NAN;
            else
                n_sum = {sa, fpadd_pkg::H_MAXMAG};
        end else if (eb == fpadd_pkg::H_EXPSPC)
            n_sum = (fb != 10'd0) ? fpadd_pkg::H_NAN : {sb, fpadd_pkg::H_MAXMAG};
        else if (a[14:0] == 15'd0)
            n_sum = b;
        else if (b[14:0] == 15'd0)
            n_sum = a;
        else if (r == 32'd0)
            n_sum = {sa & sb, 15'd0};
        else if (!rexp[7] && rexp >= 8'd31)
            n_sum = {sa, fpadd_pkg::H_MAXMAG};
        else if (rexp[7] || rexp == 8'd0)
            n_sum = {sa, 5'd0, rm[9:0]};
        else
            n_sum = {sa, rexp[4:0], rm[9:0]};
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $past(r_in_vld)) else $error("result without item");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |=> r_out_vld) else $error("item lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_a[14:10] == fpadd_pkg::H_EXPSPC && r_a[9:0] != 10'd0)
        |=> (r_sum == fpadd_pkg::H_NAN))
        else $error("NaN not propagated");
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for fp16_adder_round_to_odd: directed and random operand pairs, each sum
// checked against a local round-to-odd binary16 adder. Depends on fpadd_pkg and the RTL.
`default_nettype none
module tb;

    class sum_board;
        logic [15:0] pending[$];
        int errors;
        int checked;

        function automatic logic [31:0] sticky_shr(logic [31:0] m, int sh);
            logic [31:0] lost;
            if (sh <= 0) return m;
            if (sh > 31) sh = 31;
            lost = m & ((32'd1 << sh) - 32'd1);
            return (m >> sh) | {31'd0, lost != 0};
        endfunction

        function automatic logic [15:0] add_rto(logic [15:0] a, logic [15:0] b);
            logic [15:0] t;
            logic sa, sb;
            logic [4:0] ea, eb;
            logic [9:0] fa, fb;
            logic [31:0] ma, mb, r, stk;
            int xa, xb, re, rexp, pos;
            if (a[14:0] == 0 && b[14:0] == 0) return a & b;
            if (a[14:0] < b[14:0]) begin
                t = a; a = b; b = t;
            end
            sa = a[15]; ea = a[14:10]; fa = a[9:0];
            sb = b[15]; eb = b[14:10]; fb = b[9:0];
            if (ea == fpadd_pkg::H_EXPSPC) begin
                if (fa != 0) return fpadd_pkg::H_NAN;
                if (eb == fpadd_pkg::H_EXPSPC && (fb != 0 || sa != sb))
                    return fpadd_pkg::H_NAN;
                return {sa, fpadd_pkg::H_MAXMAG};
            end
            if (eb == fpadd_pkg::H_EXPSPC) begin
                if (fb != 0) return fpadd_pkg::H_NAN;
                return {sb, fpadd_pkg::H_MAXMAG};
            end
            if (a[14:0] == 0) return b;
            if (b[14:0] == 0) return a;
            xa = int'(ea) + (ea == 0) - fpadd_pkg::H_BIAS;
            xb = int'(eb) + (eb == 0) - fpadd_pkg::H_BIAS;
            ma = {21'd0, ea != 0, fa} << fpadd_pkg::H_EXTRA;
            mb = {21'd0, eb != 0, fb} << fpadd_pkg::H_EXTRA;
            mb = sticky_shr(mb, xa - xb);
            re = xa;
            r = (sa == sb) ? ma + mb : ma - mb;
            if (r == 0) return {sa & sb, 15'd0};
            if (r >= (32'd1 << (fpadd_pkg::H_LEAD + 1))) begin
                r = (r >> 1) | (r & 32'd1);
                re++;
            end
            pos = 31;
            while (!r[pos]) pos--;
            if (pos < fpadd_pkg::H_LEAD) begin
                r = r << (fpadd_pkg::H_LEAD - pos);
                re -= fpadd_pkg::H_LEAD - pos;
            end
            rexp = re + fpadd_pkg::H_BIAS;
            if (rexp >= int'(fpadd_pkg::H_EXPSPC)) return {sa, fpadd_pkg::H_MAXMAG};
            if (rexp <= 0) begin
                r = sticky_shr(r, 1 - rexp);
                rexp = 0;
            end
            stk = r & ((32'd1 << fpadd_pkg::H_EXTRA) - 32'd1);
            r = r >> fpadd_pkg::H_EXTRA;
            if (stk != 0) r[0] = 1'b1;
            return {sa, rexp[4:0], r[9:0]};
        endfunction

        function void note_item(logic [15:0] a, logic [15:0] b);
            pending.push_back(add_rto(a, b));
        endfunction

        function void check_sum(logic [15:0] got);
            logic [15:0] want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected sum %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("sum mismatch: expected %h got %h", want, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy, o_done;
    logic [15:0] i_a_operand, i_b_operand, o_sum_value;
    sum_board board;
    int cycles;
    int n_items;
    bit calm;

    fp16_adder_round_to_odd dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_operand(i_a_operand), .i_b_operand(i_b_operand),
        .o_done(o_done), .o_sum_value(o_sum_value)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) board.check_sum(o_sum_value);
        if (cycles > 200000) begin
            $display("timeout");
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [15:0] rand_half();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 7))
            0: v[14:10] = 5'd0;
            1: v[14:10] = 5'd31;
            2: v[14:10] = 5'd30;
            3: v[14:0] = 15'd0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_item(logic [15:0] a, logic [15:0] b);
        while (!calm && $urandom_range(0, 99) < 8) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_a_operand <= a;
        i_b_operand <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(a, b);
        n_items++;
    endtask

    task automatic send_close(logic [15:0] a);
        logic [15:0] b;
        b = a ^ 16'h8000;
        b[14:10] = a[14:10] - 5'($urandom_range(0, 3));
        b[9:0] = 10'($urandom);
        send_item(a, b);
    endtask

    initial begin
        logic [15:0] dir_a[$], dir_b[$];
        board = new();
        cycles = 0;
        n_items = 0;
        calm = 0;
        i_rst_n = 0;
        start = 0;
        i_a_operand = 0;
        i_b_operand = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        dir_a = '{16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'h3C00, 16'h7E01, 16'h3C00,
                  16'h7C00, 16'h7C00, 16'hFC00, 16'h3C00, 16'h7BFF, 16'hFBFF, 16'h0001,
                  16'h0400, 16'h3C01, 16'hFFFF, 16'h03FF, 16'h3C00, 16'h0001, 16'h5BFF};
        dir_b = '{16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h3C00, 16'hFE00,
                  16'hFC00, 16'h7C00, 16'h3C00, 16'hBC00, 16'h7BFF, 16'hFBFF, 16'h8001,
                  16'h8001, 16'h1001, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001, 16'hDBFE};
        foreach (dir_a[k]) send_item(dir_a[k], dir_b[k]);
        for (int k = 0; k < 1400; k++) begin
            calm = (k >= 500 && k < 700);
            if ($urandom_range(0, 4) == 0) send_close(rand_half());
            else send_item(rand_half(), rand_half());
        end
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        $display("%0d operand pairs sent, %0d sums checked", n_items, board.checked);
        $display("zeros, NaNs, infinities, overflow, subnormals and cancellation included");
        if (board.errors == 0 && board.pending.size() == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/fpadd_pkg.sv
rtl/core/fp16_adder_round_to_odd.sv
test/tb.sv
